@@ hdl/piecewise_ilstd_update_core_assert.svh @@
// assertion macros for the piecewise ilstd update core
// expects clk and rst_n in the scope of the including module
`ifndef PIECEWISE_ILSTD_UPDATE_CORE_ASSERT_SVH
`define PIECEWISE_ILSTD_UPDATE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PILU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PILU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pilu_pkg.sv @@
// shared types, codes and fixed point helpers of the piecewise ilstd core
// no dependencies
`timescale 1ns / 1ps

package pilu_pkg;

  localparam int DATA_W  = 32;
  localparam int ACC_W   = 48;
  localparam int MOP_W   = 33;
  localparam int PROD_W  = 66;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;
  localparam int BLK_W   = 3;
  localparam int GS_W    = 7;
  localparam int FRAC_W  = 17;

  localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sd65536;

  // action and result kind codes
  localparam logic [1:0] ACT_TRANS = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_PRED  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // register indexes
  localparam logic [1:0] REG_DISCOUNT = 2'd0;
  localparam logic [1:0] REG_STEP     = 2'd1;
  localparam logic [1:0] REG_GREEDY   = 2'd2;

  typedef struct packed {
    logic [FRAC_W-1:0] discount;
    logic [FRAC_W-1:0] step_size;
    logic [GS_W-1:0]   greedy_steps;
  } cfg_t;

  typedef struct packed {
    logic                     clip;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_D_MUL, ST_D_SUB, ST_ROW, ST_COL_RD, ST_COL_UPD,
    ST_COL_ACC, ST_ROW_FR, ST_ROW_WR, ST_G_SCAN, ST_G_LAST, ST_G_STEP,
    ST_G_TH, ST_G_MU_RD, ST_G_MU_MUL, ST_G_MU_WR, ST_P_RD, ST_P_MUL,
    ST_P_ACC, ST_DONE
  } state_t;

  // clip a wide signed value to 32 bits
  function automatic sat_t clip_wide(input logic signed [PROD_W-1:0] v);
    sat_t r;
    r.clip = 1'b0;
    r.val  = $signed(v[DATA_W-1:0]);
    if (v > 66'sh7FFFFFFF) begin
      r.clip = 1'b1;
      r.val  = 32'sh7FFFFFFF;
    end else if (v < -66'sh80000000) begin
      r.clip = 1'b1;
      r.val  = 32'sh80000000;
    end
    return r;
  endfunction

  // round to nearest, ties upward, then clip
  function automatic sat_t qround(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = (p + 66'sd32768) >>> 16;
    return clip_wide(t);
  endfunction

  function automatic sat_t sat_add(input logic signed [DATA_W-1:0] a,
                                   input logic signed [DATA_W-1:0] b);
    return clip_wide(PROD_W'(a) + PROD_W'(b));
  endfunction

  function automatic sat_t sat_sub(input logic signed [DATA_W-1:0] a,
                                   input logic signed [DATA_W-1:0] b);
    return clip_wide(PROD_W'(a) - PROD_W'(b));
  endfunction

endpackage

@@ hdl/piecewise_ilstd_update_core.sv @@
// Incremental LSTD learner with piecewise-linear features, Q16.16 saturating.
// Matrix A, residual mu and weights theta live in three registered-read
// memories worked by one sequencer and one shared 33x33 multiplier. A
// non-final element is only buffered. A final transition element updates
// the live rows of A and mu over the S feature columns touched (BLOCK_SIZE,
// or 2*BLOCK_SIZE for distinct blocks), then runs G greedy steps, with
// G the greedy step count and P = PARAM_COUNT; each greedy step scans mu once
// and then rewrites every mu entry through the A column. A prediction
// accumulates theta over the BLOCK_SIZE rows of its block. Reset and a clear
// both sweep all 2^(2*ceil(log2 P)) entries of the A memory (4096 by default),
// with input held off; configuration writes are taken at any time. Each result
// waits in an output register while the next elements are accepted.
`timescale 1ns / 1ps
`include "piecewise_ilstd_update_core_assert.svh"

module piecewise_ilstd_update_core #(
  parameter int REF_COUNT   = 8,
  parameter int BLOCK_SIZE  = 8,
  parameter int PARAM_COUNT = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  // configuration port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready,
  // input words
  input  logic         in_tvalid,
  output logic         in_tready,
  // state_elem[31:0], next_state_elem[63:32], block_index[66:64],
  // next_block_index[69:67], reward[101:70], zero pad
  input  logic [103:0] in_tdata,
  // action
  input  logic [1:0]   in_tuser,
  input  logic         in_tlast,
  // result words
  output logic         out_tvalid,
  input  logic         out_tready,
  // prediction[31:0], saturated[32], zero pad
  output logic [39:0]  out_tdata,
  // kind
  output logic [1:0]   out_tuser
);
  import pilu_pkg::*;

  localparam int AW      = $clog2(PARAM_COUNT);
  localparam int A_DEPTH = 1 << (2 * AW);
  localparam int V_DEPTH = 1 << AW;
  localparam int ELEMS   = BLOCK_SIZE - 1;
  localparam int OW      = $clog2(BLOCK_SIZE);
  localparam int SW      = $clog2(2 * BLOCK_SIZE);
  localparam int IW      = $clog2(REF_COUNT * BLOCK_SIZE + PARAM_COUNT);
  localparam int CW      = 2 * AW;

  // configuration
  cfg_t cfg;

  pilu_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // shared multiplier
  logic signed [MOP_W-1:0] mul_a, mul_b;
  sat_t                    qres;

  pilu_qmul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .res   (qres)
  );

  // memories
  logic signed [DATA_W-1:0] a_mem  [A_DEPTH];
  logic signed [DATA_W-1:0] mu_mem [V_DEPTH];
  logic signed [DATA_W-1:0] th_mem [V_DEPTH];

  logic                     a_we, mu_we, th_we;
  logic [CW-1:0]            a_waddr, a_raddr;
  logic [AW-1:0]            mu_waddr, mu_raddr, th_waddr, th_raddr;
  logic signed [DATA_W-1:0] a_wdata, mu_wdata, th_wdata;
  logic signed [DATA_W-1:0] a_rdata_r, mu_rdata_r, th_rdata_r;

  always_ff @(posedge clk) begin
    if (a_we) a_mem[a_waddr] <= a_wdata;
    a_rdata_r <= a_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (mu_we) mu_mem[mu_waddr] <= mu_wdata;
    mu_rdata_r <= mu_mem[mu_raddr];
  end

  always_ff @(posedge clk) begin
    if (th_we) th_mem[th_waddr] <= th_wdata;
    th_rdata_r <= th_mem[th_raddr];
  end

  // control and datapath registers
  state_t                   state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic                     clr_theta_r, clr_theta_nxt;
  logic [OW-1:0]            elem_cnt_r, elem_cnt_nxt;
  logic [1:0]               act_r, act_nxt;
  logic [IW-1:0]            cbase_r, cbase_nxt, nbase_r, nbase_nxt;
  logic signed [DATA_W-1:0] reward_r, reward_nxt;
  logic signed [DATA_W-1:0] cbuf_r [ELEMS];
  logic signed [DATA_W-1:0] nbuf_r [ELEMS];
  logic signed [DATA_W-1:0] d_r [2*BLOCK_SIZE];
  logic                     d_we;
  logic signed [DATA_W-1:0] d_wdata;
  logic [SW-1:0]            slot_r, slot_nxt;
  logic [OW-1:0]            row_r, row_nxt;
  logic [AW-1:0]            k_r, k_nxt, kd_r, j_r, j_nxt;
  logic [GS_W-1:0]          n_r, n_nxt;
  logic [DATA_W-1:0]        best_r, best_nxt;
  logic                     bhave_r, bhave_nxt, scan_v_r;
  logic signed [DATA_W-1:0] bestval_r, bestval_nxt, step_r, step_nxt;
  logic signed [DATA_W-1:0] muh_r, muh_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     sat_r, sat_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_kind_r, out_kind_nxt;
  logic signed [DATA_W-1:0] out_pred_r, out_pred_nxt;
  logic                     out_sat_r, out_sat_nxt;

  // input word decode
  logic                     in_acc, in_elem;
  logic [BLK_W-1:0]         cblk_in, nblk_in;
  logic [IW-1:0]            cbase_in, nbase_in;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_elem   = (in_tuser == ACT_TRANS) || (in_tuser == ACT_PRED);
  assign cblk_in   = in_tdata[66:64];
  assign nblk_in   = in_tdata[69:67];
  assign cbase_in  = (int'(cblk_in) >= REF_COUNT - 1) ?
                     IW'((REF_COUNT - 1) * BLOCK_SIZE) :
                     IW'(cblk_in) * IW'(BLOCK_SIZE);
  assign nbase_in  = (int'(nblk_in) >= REF_COUNT - 1) ?
                     IW'((REF_COUNT - 1) * BLOCK_SIZE) :
                     IW'(nblk_in) * IW'(BLOCK_SIZE);

  // feature lookups for the current row and column slot
  logic [IW-1:0]            row_addr, col_addr;
  logic [SW-1:0]            slot_off;
  logic [OW-1:0]            slot_o;
  logic                     row_rng, row_ok, row_last, same_blk, slot_last, col_ok;
  logic                     k_last, n_last, greedy_zero, out_free;
  logic signed [DATA_W-1:0] f_row, f_col, g_col, f_slot, g_slot;
  logic [DATA_W-1:0]        mag;
  sat_t                     pred_c;

  assign row_addr  = cbase_r + IW'(row_r);
  assign row_rng   = row_addr < IW'(PARAM_COUNT);
  assign f_row     = (int'(row_r) < ELEMS) ? cbuf_r[row_r] : ONE_Q16;
  assign row_ok    = row_rng && (f_row != '0);
  assign row_last  = (row_r == OW'(BLOCK_SIZE - 1));
  assign same_blk  = (cbase_r == nbase_r);
  assign slot_last = same_blk ? (slot_r == SW'(BLOCK_SIZE - 1)) :
                                (slot_r == SW'(2 * BLOCK_SIZE - 1));
  assign slot_off  = (slot_r < SW'(BLOCK_SIZE)) ? slot_r : slot_r - SW'(BLOCK_SIZE);
  assign slot_o    = OW'(slot_off);
  assign col_addr  = (slot_r < SW'(BLOCK_SIZE)) ? cbase_r + IW'(slot_o) :
                                                   nbase_r + IW'(slot_o);
  assign col_ok    = col_addr < IW'(PARAM_COUNT);
  assign f_slot    = (int'(slot_o) < ELEMS) ? cbuf_r[slot_o] : ONE_Q16;
  assign g_slot    = (int'(slot_o) < ELEMS) ? nbuf_r[slot_o] : ONE_Q16;
  assign f_col     = (slot_r < SW'(BLOCK_SIZE)) ? f_slot : '0;
  assign g_col     = (slot_r < SW'(BLOCK_SIZE)) ? (same_blk ? g_slot : '0) : g_slot;
  assign k_last    = (k_r == AW'(PARAM_COUNT - 1));
  assign n_last    = ((n_r + GS_W'(1)) == cfg.greedy_steps);
  assign greedy_zero = (cfg.greedy_steps == '0);
  assign out_free  = !out_valid_r || out_tready;
  assign mag       = mu_rdata_r[DATA_W-1] ? (~mu_rdata_r + DATA_W'(1)) : mu_rdata_r;
  assign pred_c    = clip_wide(PROD_W'(acc_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (cnt_r == CW'(A_DEPTH - 1)) state_nxt = clr_theta_r ? ST_IDLE : ST_DONE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == ACT_CLEAR) state_nxt = ST_CLEAR;
          else if (in_elem && in_tlast)
            state_nxt = (in_tuser == ACT_TRANS) ? ST_D_MUL : ST_P_RD;
        end
      end
      ST_D_MUL:   state_nxt = ST_D_SUB;
      ST_D_SUB:   state_nxt = slot_last ? ST_ROW : ST_D_MUL;
      ST_ROW: begin
        if (row_ok) state_nxt = ST_COL_RD;
        else if (row_last) state_nxt = greedy_zero ? ST_DONE : ST_G_SCAN;
      end
      ST_COL_RD: begin
        if (col_ok) state_nxt = ST_COL_UPD;
        else if (slot_last) state_nxt = ST_ROW_FR;
      end
      ST_COL_UPD: state_nxt = ST_COL_ACC;
      ST_COL_ACC: state_nxt = slot_last ? ST_ROW_FR : ST_COL_RD;
      ST_ROW_FR:  state_nxt = ST_ROW_WR;
      ST_ROW_WR: begin
        if (!row_last) state_nxt = ST_ROW;
        else state_nxt = greedy_zero ? ST_DONE : ST_G_SCAN;
      end
      ST_G_SCAN:   state_nxt = k_last ? ST_G_LAST : ST_G_SCAN;
      ST_G_LAST:   state_nxt = ST_G_STEP;
      ST_G_STEP:   state_nxt = ST_G_TH;
      ST_G_TH:     state_nxt = ST_G_MU_RD;
      ST_G_MU_RD:  state_nxt = ST_G_MU_MUL;
      ST_G_MU_MUL: state_nxt = ST_G_MU_WR;
      ST_G_MU_WR: begin
        if (!k_last) state_nxt = ST_G_MU_RD;
        else state_nxt = n_last ? ST_DONE : ST_G_SCAN;
      end
      ST_P_RD: begin
        if (row_rng) state_nxt = ST_P_MUL;
        else if (row_last) state_nxt = ST_DONE;
      end
      ST_P_MUL:   state_nxt = ST_P_ACC;
      ST_P_ACC:   state_nxt = row_last ? ST_DONE : ST_P_RD;
      ST_DONE:    state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    sat_t s0, s1;
    cnt_nxt       = cnt_r;
    clr_theta_nxt = clr_theta_r;
    elem_cnt_nxt  = elem_cnt_r;
    act_nxt       = act_r;
    cbase_nxt     = cbase_r;
    nbase_nxt     = nbase_r;
    reward_nxt    = reward_r;
    slot_nxt      = slot_r;
    row_nxt       = row_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    n_nxt         = n_r;
    best_nxt      = best_r;
    bhave_nxt     = bhave_r;
    bestval_nxt   = bestval_r;
    step_nxt      = step_r;
    muh_nxt       = muh_r;
    acc_nxt       = acc_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_pred_nxt  = out_pred_r;
    out_sat_nxt   = out_sat_r;
    d_we          = 1'b0;
    d_wdata       = '0;
    a_we = 1'b0;  a_waddr  = '0; a_wdata  = '0; a_raddr  = '0;
    mu_we = 1'b0; mu_waddr = '0; mu_wdata = '0; mu_raddr = '0;
    th_we = 1'b0; th_waddr = '0; th_wdata = '0; th_raddr = '0;
    mul_a = '0;
    mul_b = '0;
    s0 = '0;
    s1 = '0;

    // running max of |mu| while the scan data streams back
    if ((state_r == ST_G_SCAN || state_r == ST_G_LAST) && scan_v_r) begin
      if (!bhave_r || mag > best_r) begin
        best_nxt    = mag;
        bhave_nxt   = 1'b1;
        j_nxt       = kd_r;
        bestval_nxt = mu_rdata_r;
      end
    end

    case (state_r)
      // zero sweep of A and mu, theta only after reset
      ST_CLEAR: begin
        a_we     = 1'b1;
        a_waddr  = cnt_r;
        mu_we    = 1'b1;
        mu_waddr = cnt_r[AW-1:0];
        th_we    = clr_theta_r;
        th_waddr = cnt_r[AW-1:0];
        cnt_nxt  = cnt_r + CW'(1);
        if (cnt_r == CW'(A_DEPTH - 1)) clr_theta_nxt = 1'b0;
      end
      // element intake
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == ACT_CLEAR) begin
            cnt_nxt      = '0;
            elem_cnt_nxt = '0;
            act_nxt      = ACT_CLEAR;
            sat_nxt      = 1'b0;
          end else if (in_elem) begin
            if (int'(elem_cnt_r) < ELEMS) elem_cnt_nxt = elem_cnt_r + OW'(1);
            if (in_tlast) begin
              elem_cnt_nxt = '0;
              act_nxt      = in_tuser;
              cbase_nxt    = cbase_in;
              nbase_nxt    = nbase_in;
              reward_nxt   = $signed(in_tdata[101:70]);
              sat_nxt      = 1'b0;
              slot_nxt     = '0;
              row_nxt      = '0;
              acc_nxt      = '0;
            end
          end
        end
      end
      // d = f - gamma * g per column slot
      ST_D_MUL: begin
        mul_a = MOP_W'(cfg.discount);
        mul_b = MOP_W'(g_col);
      end
      ST_D_SUB: begin
        s0 = sat_sub(f_col, qres.val);
        if (col_ok) begin
          d_we    = 1'b1;
          d_wdata = s0.val;
          sat_nxt = sat_r | qres.clip | s0.clip;
        end
        slot_nxt = slot_last ? '0 : slot_r + SW'(1);
      end
      // row start, skip rows with a zero feature or outside the parameter range
      ST_ROW: begin
        acc_nxt  = '0;
        slot_nxt = '0;
        if (!row_ok) begin
          row_nxt = row_r + OW'(1);
          k_nxt = '0; n_nxt = '0; bhave_nxt = 1'b0;
        end
      end
      ST_COL_RD: begin
        if (col_ok) begin
          a_raddr  = {row_addr[AW-1:0], col_addr[AW-1:0]};
          th_raddr = col_addr[AW-1:0];
          mul_a    = MOP_W'(f_row);
          mul_b    = MOP_W'(d_r[slot_r]);
        end else begin
          slot_nxt = slot_r + SW'(1);
        end
      end
      // A entry update, then da * theta
      ST_COL_UPD: begin
        s0      = sat_add(a_rdata_r, qres.val);
        a_we    = 1'b1;
        a_waddr = {row_addr[AW-1:0], col_addr[AW-1:0]};
        a_wdata = s0.val;
        sat_nxt = sat_r | qres.clip | s0.clip;
        mul_a   = MOP_W'(qres.val);
        mul_b   = MOP_W'(th_rdata_r);
      end
      ST_COL_ACC: begin
        acc_nxt  = acc_r + ACC_W'(qres.val);
        sat_nxt  = sat_r | qres.clip;
        slot_nxt = slot_r + SW'(1);
      end
      // mu[r] += f*reward - s
      ST_ROW_FR: begin
        mul_a    = MOP_W'(f_row);
        mul_b    = MOP_W'(reward_r);
        mu_raddr = row_addr[AW-1:0];
      end
      ST_ROW_WR: begin
        s0       = clip_wide(PROD_W'(qres.val) - PROD_W'(acc_r));
        s1       = sat_add(mu_rdata_r, s0.val);
        mu_we    = 1'b1;
        mu_waddr = row_addr[AW-1:0];
        mu_wdata = s1.val;
        sat_nxt  = sat_r | qres.clip | s0.clip | s1.clip;
        row_nxt  = row_r + OW'(1);
        acc_nxt  = '0;
        slot_nxt = '0;
        k_nxt = '0; n_nxt = '0; bhave_nxt = 1'b0;
      end
      // greedy scan of mu
      ST_G_SCAN: begin
        mu_raddr = k_r;
        k_nxt    = k_r + AW'(1);
      end
      ST_G_LAST: k_nxt = '0;
      ST_G_STEP: begin
        mul_a    = MOP_W'(cfg.step_size);
        mul_b    = MOP_W'(bestval_r);
        th_raddr = j_r;
      end
      ST_G_TH: begin
        s0       = sat_add(th_rdata_r, qres.val);
        th_we    = 1'b1;
        th_waddr = j_r;
        th_wdata = s0.val;
        step_nxt = qres.val;
        sat_nxt  = sat_r | qres.clip | s0.clip;
        k_nxt    = '0;
      end
      // mu -= step * A[.][j]
      ST_G_MU_RD: begin
        mu_raddr = k_r;
        a_raddr  = {k_r, j_r};
      end
      ST_G_MU_MUL: begin
        mul_a   = MOP_W'(step_r);
        mul_b   = MOP_W'(a_rdata_r);
        muh_nxt = mu_rdata_r;
      end
      ST_G_MU_WR: begin
        s0       = sat_sub(muh_r, qres.val);
        mu_we    = 1'b1;
        mu_waddr = k_r;
        mu_wdata = s0.val;
        sat_nxt  = sat_r | qres.clip | s0.clip;
        k_nxt    = k_r + AW'(1);
        if (k_last) begin
          k_nxt     = '0;
          n_nxt     = n_r + GS_W'(1);
          bhave_nxt = 1'b0;
        end
      end
      // prediction dot product
      ST_P_RD: begin
        if (row_rng) th_raddr = row_addr[AW-1:0];
        else row_nxt = row_r + OW'(1);
      end
      ST_P_MUL: begin
        mul_a = MOP_W'(f_row);
        mul_b = MOP_W'(th_rdata_r);
      end
      ST_P_ACC: begin
        acc_nxt = acc_r + ACC_W'(qres.val);
        sat_nxt = sat_r | qres.clip;
        row_nxt = row_r + OW'(1);
      end
      // result word into the output register
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = act_r;
          out_pred_nxt  = (act_r == ACT_PRED) ? pred_c.val : '0;
          out_sat_nxt   = sat_r | ((act_r == ACT_PRED) & pred_c.clip);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      clr_theta_r <= 1'b1;
      elem_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      scan_v_r    <= 1'b0;
      bhave_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_theta_r <= clr_theta_nxt;
      elem_cnt_r  <= elem_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      scan_v_r    <= (state_r == ST_G_SCAN);
      bhave_r     <= bhave_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    cbase_r    <= cbase_nxt;
    nbase_r    <= nbase_nxt;
    reward_r   <= reward_nxt;
    slot_r     <= slot_nxt;
    row_r      <= row_nxt;
    k_r        <= k_nxt;
    kd_r       <= k_r;
    j_r        <= j_nxt;
    n_r        <= n_nxt;
    best_r     <= best_nxt;
    bestval_r  <= bestval_nxt;
    step_r     <= step_nxt;
    muh_r      <= muh_nxt;
    acc_r      <= acc_nxt;
    sat_r      <= sat_nxt;
    out_kind_r <= out_kind_nxt;
    out_pred_r <= out_pred_nxt;
    out_sat_r  <= out_sat_nxt;
    if (d_we) d_r[slot_r] <= d_wdata;
    if (in_acc && in_elem && (int'(elem_cnt_r) < ELEMS)) begin
      cbuf_r[elem_cnt_r] <= $signed(in_tdata[31:0]);
      nbuf_r[elem_cnt_r] <= $signed(in_tdata[63:32]);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_sat_r, out_pred_r};
  assign out_tuser  = out_kind_r;

  // checks
  `PILU_ASSERT_NOW(a_pick_in_range, state_r == ST_G_STEP, int'(j_r) < PARAM_COUNT,
                   "greedy pick beyond parameter count")
  `PILU_ASSERT_NOW(a_mat_write_src, a_we,
                   state_r == ST_CLEAR || state_r == ST_COL_UPD,
                   "matrix written outside sweep or row update")
  `PILU_ASSERT_NOW(a_result_from_done, $rose(out_valid_r), $past(state_r) == ST_DONE,
                   "result raised without finishing an item")

endmodule

@@ hdl/pilu_qmul.sv @@
// shared q16.16 multiplier: registered product, rounded and clipped after
// depends on pilu_pkg
`timescale 1ns / 1ps

module pilu_qmul (
  input  logic                              clk,
  input  logic signed [pilu_pkg::MOP_W-1:0] mul_a,
  input  logic signed [pilu_pkg::MOP_W-1:0] mul_b,
  output pilu_pkg::sat_t                    res
);
  import pilu_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  // product register
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // rounding and clipping of the stored product
  assign res = qround(prod_r);

endmodule

@@ hdl/pilu_cfg_regs.sv @@
// apb register bank: discount, step size and greedy step count
// depends on pilu_pkg
`timescale 1ns / 1ps

module pilu_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pilu_pkg::CFG_AW-1:0]  paddr,
  input  logic [pilu_pkg::CFG_DW-1:0]  pwdata,
  output logic [pilu_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output pilu_pkg::cfg_t               cfg
);
  import pilu_pkg::*;

  cfg_t       cfg_r;
  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.discount     <= FRAC_W'(62259);
      cfg_r.step_size    <= FRAC_W'(655);
      cfg_r.greedy_steps <= GS_W'(1);
    end else if (wr) begin
      case (idx)
        REG_DISCOUNT: cfg_r.discount     <= pwdata[FRAC_W-1:0];
        REG_STEP:     cfg_r.step_size    <= pwdata[FRAC_W-1:0];
        REG_GREEDY:   cfg_r.greedy_steps <= pwdata[GS_W-1:0];
        default:      ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_DISCOUNT: prdata = CFG_DW'(cfg_r.discount);
      REG_STEP:     prdata = CFG_DW'(cfg_r.step_size);
      REG_GREEDY:   prdata = CFG_DW'(cfg_r.greedy_steps);
      default:      prdata = '0;
    endcase
  end

endmodule

@@ sim/piecewise_ilstd_update_core_tb.sv @@
// testbench of the piecewise ilstd update core: random and directed words,
// a saturating Q16.16 predictor of A, mu and theta, in-order result checking
// depends on pilu_pkg and piecewise_ilstd_update_core
`timescale 1ns / 1ps

module piecewise_ilstd_update_core_tb;
  import pilu_pkg::*;

  localparam int  NBLK   = 8;
  localparam int  BSZ    = 8;
  localparam int  NPAR   = 64;
  localparam int  NELEM  = BSZ - 1;
  localparam int  TAIL   = 64;
  localparam longint CYCLE_LIMIT = 40000000;

  typedef struct {
    logic [1:0]  action;
    logic [31:0] s_elem;
    logic [31:0] ns_elem;
    logic [2:0]  blk;
    logic [2:0]  nblk;
    logic [31:0] reward;
    logic        last;
  } elem_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] pred;
    logic        sat;
  } result_t;

  typedef int vec_t [NPAR];

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [39:0]  out_tdata;
  logic [1:0]   out_tuser;

  piecewise_ilstd_update_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #4 clk = ~clk;

  // learner copy: registers, A, mu, theta, element buffers
  longint      gamma_q, alpha_q, greedy_n;
  int          amat [NPAR][NPAR];
  int          mu_vec [NPAR];
  int          theta_vec [NPAR];
  int          cur_buf [NELEM];
  int          nxt_buf [NELEM];
  int unsigned elem_cnt;
  bit          clipped;

  elem_t   pend_words [$];
  result_t exp_results [$];
  elem_t   cur_word;
  int      err_count = 0;
  bit      quiet = 1'b0;
  bit      in_taken = 1'b0;
  int      in_gap = 0;
  int      out_stall = 0;
  longint  cycles = 0;

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return 32'sh80000000;
    end
    return int'(v);
  endfunction

  // round to nearest, ties upward
  function automatic int qmul(longint a, longint b);
    return clip32((a * b + 64'sd32768) >>> 16);
  endfunction

  function automatic void build_feat(output vec_t f, input int unsigned blk, input bit nxt);
    int unsigned base;
    base = blk * BSZ;
    foreach (f[i]) f[i] = 0;
    for (int i = 0; i < NELEM; i++)
      if (base + i < NPAR) f[base + i] = nxt ? nxt_buf[i] : cur_buf[i];
    if (base + NELEM < NPAR) f[base + NELEM] = 65536;
  endfunction

  function automatic void learn_transition(int unsigned blk, int unsigned nblk, longint rew);
    vec_t    f, g, d;
    longint  acc, best, m;
    int      upd, step, j;
    build_feat(f, blk, 1'b0);
    build_feat(g, nblk, 1'b1);
    for (int c = 0; c < NPAR; c++) d[c] = clip32(longint'(f[c]) - qmul(gamma_q, g[c]));
    // rank-one update of the live rows
    for (int r = 0; r < NPAR; r++) begin
      if (f[r] != 0) begin
        acc = 0;
        for (int c = 0; c < NPAR; c++) begin
          upd = qmul(f[r], d[c]);
          amat[r][c] = clip32(longint'(amat[r][c]) + upd);
          acc += qmul(upd, theta_vec[c]);
        end
        upd = clip32(longint'(qmul(f[r], rew)) - acc);
        mu_vec[r] = clip32(longint'(mu_vec[r]) + upd);
      end
    end
    // greedy steps on the largest residual
    for (longint n = 0; n < greedy_n; n++) begin
      best = -1;
      j = 0;
      for (int k = 0; k < NPAR; k++) begin
        m = mu_vec[k];
        if (m < 0) m = -m;
        if (m > best) begin
          best = m;
          j = k;
        end
      end
      step = qmul(alpha_q, mu_vec[j]);
      theta_vec[j] = clip32(longint'(theta_vec[j]) + step);
      for (int k = 0; k < NPAR; k++)
        mu_vec[k] = clip32(longint'(mu_vec[k]) - qmul(step, amat[k][j]));
    end
  endfunction

  function automatic int predict_value(int unsigned blk);
    vec_t   f;
    longint acc;
    build_feat(f, blk, 1'b0);
    acc = 0;
    for (int c = 0; c < NPAR; c++) acc += qmul(f[c], theta_vec[c]);
    return clip32(acc);
  endfunction

  // advance the learner by one word, queue the result it causes
  function automatic void learner_word(elem_t w);
    result_t res;
    if (w.action == ACT_NONE) return;
    if (w.action == ACT_CLEAR) begin
      foreach (amat[r, c]) amat[r][c] = 0;
      foreach (mu_vec[k]) mu_vec[k] = 0;
      elem_cnt = 0;
      res.kind = ACT_CLEAR;
      res.pred = '0;
      res.sat = 1'b0;
      exp_results.push_back(res);
      return;
    end
    if (elem_cnt < NELEM) begin
      cur_buf[elem_cnt] = int'(w.s_elem);
      nxt_buf[elem_cnt] = int'(w.ns_elem);
      elem_cnt++;
    end
    if (!w.last) return;
    elem_cnt = 0;
    clipped = 1'b0;
    res.pred = '0;
    if (w.action == ACT_TRANS)
      learn_transition(w.blk, w.nblk, longint'(int'(w.reward)));
    else
      res.pred = predict_value(w.blk);
    res.kind = w.action;
    res.sat = clipped;
    exp_results.push_back(res);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_count++;
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [31:0] rand_q(bit ext);
    int r;
    if (ext) begin
      r = $urandom_range(0, 3);
      case (r)
        0: return 32'h7FFFFFFF;
        1: return 32'h80000000;
        2: return 32'h00000000;
        default: return 32'hFFFFFFFF;
      endcase
    end
    r = $urandom_range(0, 99);
    if (r < 70) return 32'(int'($urandom_range(0, 262143)) - 131072);
    if (r < 90) return 32'(int'($urandom_range(0, 33554431)) - 16777216);
    return $urandom;
  endfunction

  task automatic push_word(logic [1:0] act, bit last, bit ext);
    elem_t w;
    w.action  = act;
    w.s_elem  = rand_q(ext);
    w.ns_elem = rand_q(ext);
    w.blk     = $urandom_range(0, NBLK - 1);
    w.nblk    = $urandom_range(0, NBLK - 1);
    w.reward  = rand_q(ext);
    w.last    = last;
    pend_words.push_back(w);
  endtask

  task automatic push_vec(logic [1:0] act, int len, bit ext);
    for (int i = 0; i < len; i++) push_word(act, i == len - 1, ext);
  endtask

  // one random sequence: mostly well-formed vectors, some noise and broken ones
  task automatic push_random_seq(bit cheap_clear);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) push_vec(ACT_TRANS, $urandom_range(1, 10), $urandom_range(0, 19) == 0);
    else if (r < 88) push_vec(ACT_PRED, $urandom_range(1, 9), 1'b0);
    else if (r < 92) begin
      if (cheap_clear) push_word(ACT_CLEAR, $urandom_range(0, 1), 1'b0);
    end else if (r < 96) push_word(ACT_NONE, $urandom_range(0, 1), 1'b0);
    else begin
      for (int i = 0; i < 4; i++) push_word(2'($urandom_range(0, 3)), i == 3, 1'b0);
      push_vec(ACT_TRANS, NELEM, 1'b0);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_DISCOUNT: gamma_q = value & 32'h1FFFF;
      REG_STEP:     alpha_q = value & 32'h1FFFF;
      default:      greedy_n = value & 32'h7F;
    endcase
  endtask

  task automatic wait_drained();
    while (pend_words.size() != 0 || in_tvalid || exp_results.size() != 0)
      @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  task automatic run_phase(int g_val, int a_val, int gs_val, int n_words, bit q);
    int start;
    write_reg(REG_DISCOUNT, g_val);
    write_reg(REG_STEP, a_val);
    write_reg(REG_GREEDY, gs_val);
    quiet = q;
    start = pend_words.size();
    while (pend_words.size() - start < n_words) push_random_seq(gs_val < 16);
    wait_drained();
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pend_words.size() != 0) begin
        cur_word = pend_words.pop_front();
        in_tdata  <= {2'b00, cur_word.reward, cur_word.nblk, cur_word.blk,
                      cur_word.ns_elem, cur_word.s_elem};
        in_tuser  <= cur_word.action;
        in_tlast  <= cur_word.last;
        in_tvalid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_stall <= pick_gap();
    end
  end

  // accepted words feed the learner, results are checked in order
  always @(posedge clk) begin
    result_t want;
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) learner_word(cur_word);
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_results.size() == 0) begin
        report_mismatch("unexpected word", {30'd0, out_tuser}, '0);
      end else begin
        want = exp_results.pop_front();
        if (out_tuser !== want.kind) report_mismatch("kind", {30'd0, out_tuser}, {30'd0, want.kind});
        if (out_tdata[31:0] !== want.pred) report_mismatch("prediction", out_tdata[31:0], want.pred);
        if (out_tdata[32] !== want.sat) report_mismatch("saturated", {31'd0, out_tdata[32]}, {31'd0, want.sat});
      end
    end
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    gamma_q = 62259;
    alpha_q = 655;
    greedy_n = 1;
    foreach (amat[r, c]) amat[r][c] = 0;
    foreach (mu_vec[k]) begin
      mu_vec[k] = 0;
      theta_vec[k] = 0;
    end
    elem_cnt = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every action, short and long vectors, ignored code
    push_vec(ACT_TRANS, 8, 1'b1);
    push_vec(ACT_PRED, 7, 1'b1);
    push_word(ACT_NONE, 1'b0, 1'b0);
    push_word(ACT_NONE, 1'b1, 1'b0);
    push_vec(ACT_TRANS, 1, 1'b1);
    push_word(ACT_CLEAR, 1'b1, 1'b0);
    push_vec(ACT_TRANS, 2, 1'b0);
    push_vec(ACT_PRED, 2, 1'b0);
    wait_drained();

    run_phase(62259, 655, 1, 300, 1'b0);
    run_phase(0, 0, 0, 150, 1'b0);
    run_phase(65536, 65536, 64, 60, 1'b0);
    run_phase(65536, 32768, 4, 250, 1'b1);
    run_phase(32768, 6553, 2, 300, 1'b0);
    run_phase($urandom_range(0, 65536), $urandom_range(0, 65536),
              $urandom_range(0, 8), 300, 1'b0);
    run_phase(131071, 1, 3, 100, 1'b0);

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
